// ===== src/scad_pkg.sv =====
package scad_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned CHAR_W = 7;

  localparam logic [CODE_W-1:0] KEY_COUNT   = 8'd84;
  localparam logic [CODE_W-1:0] SC_ESC      = 8'd1;
  localparam logic [CODE_W-1:0] SC_CTRL     = 8'd29;
  localparam logic [CODE_W-1:0] SC_LSHIFT   = 8'd42;
  localparam logic [CODE_W-1:0] SC_SLASH    = 8'd53;
  localparam logic [CODE_W-1:0] SC_RSHIFT   = 8'd54;
  localparam logic [CODE_W-1:0] SC_ALT      = 8'd56;
  localparam logic [CODE_W-1:0] SC_CAPS     = 8'd58;
  localparam logic [CODE_W-1:0] SC_CTRL_UP  = 8'd157;
  localparam logic [CODE_W-1:0] SC_LSHIFT_UP = 8'd170;
  localparam logic [CODE_W-1:0] SC_RSHIFT_UP = 8'd182;

  localparam logic [CHAR_W-1:0] CH_NONE     = 7'h00;
  localparam logic [CHAR_W-1:0] CH_SLASH    = 7'h2F;
  localparam logic [CHAR_W-1:0] CH_QUESTION = 7'h3F;

  typedef struct packed {
    logic [CHAR_W-1:0] plain;
    logic [CHAR_W-1:0] shifted;
  } key_chars_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              suppress;
    logic [CODE_W-1:0] scan_echo;
    logic              shift_held;
    logic              ctrl_held;
    logic              alt_seen;
    logic              caps_seen;
  } result_t;

  function automatic key_chars_t key_lookup(input logic [CODE_W-1:0] code);
    key_chars_t k;
    k = '{plain: CH_NONE, shifted: CH_NONE};
    case (code)
      8'd2:  k = '{plain: 7'h31, shifted: 7'h21};
      8'd3:  k = '{plain: 7'h32, shifted: 7'h40};
      8'd4:  k = '{plain: 7'h33, shifted: 7'h23};
      8'd5:  k = '{plain: 7'h34, shifted: 7'h24};
      8'd6:  k = '{plain: 7'h35, shifted: 7'h25};
      8'd7:  k = '{plain: 7'h36, shifted: 7'h5E};
      8'd8:  k = '{plain: 7'h37, shifted: 7'h26};
      8'd9:  k = '{plain: 7'h38, shifted: 7'h2A};
      8'd10: k = '{plain: 7'h39, shifted: 7'h28};
      8'd11: k = '{plain: 7'h30, shifted: 7'h29};
      8'd12: k = '{plain: 7'h2D, shifted: 7'h5F};
      8'd13: k = '{plain: 7'h3D, shifted: 7'h2B};
      8'd14: k = '{plain: 7'h08, shifted: 7'h08};
      8'd15: k = '{plain: 7'h09, shifted: 7'h09};
      8'd16: k = '{plain: 7'h71, shifted: 7'h51};
      8'd17: k = '{plain: 7'h77, shifted: 7'h57};
      8'd18: k = '{plain: 7'h65, shifted: 7'h45};
      8'd19: k = '{plain: 7'h72, shifted: 7'h52};
      8'd20: k = '{plain: 7'h74, shifted: 7'h54};
      8'd21: k = '{plain: 7'h79, shifted: 7'h59};
      8'd22: k = '{plain: 7'h75, shifted: 7'h55};
      8'd23: k = '{plain: 7'h69, shifted: 7'h49};
      8'd24: k = '{plain: 7'h6F, shifted: 7'h4F};
      8'd25: k = '{plain: 7'h70, shifted: 7'h50};
      8'd26: k = '{plain: 7'h5B, shifted: 7'h7B};
      8'd27: k = '{plain: 7'h5D, shifted: 7'h7D};
      8'd28: k = '{plain: 7'h0A, shifted: 7'h0A};
      8'd30: k = '{plain: 7'h61, shifted: 7'h41};
      8'd31: k = '{plain: 7'h73, shifted: 7'h53};
      8'd32: k = '{plain: 7'h64, shifted: 7'h44};
      8'd33: k = '{plain: 7'h66, shifted: 7'h46};
      8'd34: k = '{plain: 7'h67, shifted: 7'h47};
      8'd35: k = '{plain: 7'h68, shifted: 7'h48};
      8'd36: k = '{plain: 7'h6A, shifted: 7'h4A};
      8'd37: k = '{plain: 7'h6B, shifted: 7'h4B};
      8'd38: k = '{plain: 7'h6C, shifted: 7'h4C};
      8'd39: k = '{plain: 7'h3B, shifted: 7'h3A};
      8'd40: k = '{plain: 7'h27, shifted: 7'h22};
      8'd41: k = '{plain: 7'h60, shifted: 7'h7E};
      8'd43: k = '{plain: 7'h5C, shifted: 7'h7C};
      8'd44: k = '{plain: 7'h7A, shifted: 7'h5A};
      8'd45: k = '{plain: 7'h78, shifted: 7'h58};
      8'd46: k = '{plain: 7'h63, shifted: 7'h43};
      8'd47: k = '{plain: 7'h76, shifted: 7'h56};
      8'd48: k = '{plain: 7'h62, shifted: 7'h42};
      8'd49: k = '{plain: 7'h6E, shifted: 7'h4E};
      8'd50: k = '{plain: 7'h6D, shifted: 7'h4D};
      8'd51: k = '{plain: 7'h2C, shifted: 7'h3C};
      8'd52: k = '{plain: 7'h2E, shifted: 7'h3E};
      8'd53: k = '{plain: 7'h2F, shifted: 7'h2F};
      8'd55: k = '{plain: 7'h2A, shifted: 7'h2A};
      8'd57: k = '{plain: 7'h20, shifted: 7'h20};
      8'd71: k = '{plain: 7'h37, shifted: 7'h37};
      8'd72: k = '{plain: 7'h38, shifted: 7'h38};
      8'd73: k = '{plain: 7'h39, shifted: 7'h39};
      8'd74: k = '{plain: 7'h2D, shifted: 7'h2D};
      8'd75: k = '{plain: 7'h34, shifted: 7'h34};
      8'd76: k = '{plain: 7'h35, shifted: 7'h35};
      8'd77: k = '{plain: 7'h36, shifted: 7'h36};
      8'd78: k = '{plain: 7'h2B, shifted: 7'h2B};
      8'd79: k = '{plain: 7'h31, shifted: 7'h31};
      8'd80: k = '{plain: 7'h32, shifted: 7'h32};
      8'd81: k = '{plain: 7'h33, shifted: 7'h33};
      8'd82: k = '{plain: 7'h30, shifted: 7'h30};
      8'd83: k = '{plain: 7'h2E, shifted: 7'h2E};
      default: k = '{plain: CH_NONE, shifted: CH_NONE};
    endcase
    return k;
  endfunction

endpackage

// ===== src/scad_in_if.sv =====
interface scad_in_if
  import scad_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

// ===== src/scad_out_if.sv =====
interface scad_out_if
  import scad_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              suppress;
  logic [CODE_W-1:0] scan_echo;
  logic              shift_held;
  logic              ctrl_held;
  logic              alt_seen;
  logic              caps_seen;

  modport source (output valid, output ascii_char, output suppress, output scan_echo,
                  output shift_held, output ctrl_held, output alt_seen, output caps_seen,
                  input ready);
  modport sink   (input valid, input ascii_char, input suppress, input scan_echo,
                  input shift_held, input ctrl_held, input alt_seen, input caps_seen,
                  output ready);
endinterface

// ===== src/scancode_to_ascii_decoder.sv =====
// Channel  Role    Payload
// in_ch    sink    scan_code
// out_ch   source  ascii_char, suppress, scan_echo, shift_held, ctrl_held, alt_seen, caps_seen
//
// One beat per cycle sustained while out_ch is ready; a scancode lands in the input
// register when accepted and moves on to the result register, which drives out_ch.
// Synchronous active-low reset empties both registers and clears all four flags.
// A stalled out_ch holds the result; the input register keeps taking a beat
// while it is empty or moving on, so in_ch stalls only when both stages are full
// and out_ch is not ready.
module scancode_to_ascii_decoder
  import scad_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  scad_in_if.sink    in_ch,
  scad_out_if.source out_ch
);

  logic              s1_valid_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;

  logic shift_r, ctrl_r, alt_r, caps_r;
  logic shift_nxt, ctrl_nxt, alt_nxt, caps_nxt;

  logic              advance;
  logic              s1_ready;
  key_chars_t        keys;
  logic [CHAR_W-1:0] ch;

  assign advance  = !out_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || advance;

  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    caps_nxt  = caps_r;
    case (s1_code_r)
      SC_CTRL:      ctrl_nxt  = 1'b1;
      SC_LSHIFT:    shift_nxt = 1'b1;
      SC_RSHIFT:    shift_nxt = 1'b1;
      SC_ALT:       alt_nxt   = 1'b1;
      SC_CAPS:      caps_nxt  = 1'b1;
      SC_CTRL_UP:   ctrl_nxt  = 1'b0;
      SC_LSHIFT_UP: shift_nxt = 1'b0;
      SC_RSHIFT_UP: shift_nxt = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    keys = key_lookup(s1_code_r);
    ch   = CH_NONE;
    if (s1_code_r < KEY_COUNT) begin
      ch = shift_r ? keys.shifted : keys.plain;
    end
    if (s1_code_r == SC_SLASH && ch == CH_SLASH && shift_nxt) begin
      ch = CH_QUESTION;
    end
    res_nxt.ascii_char = ch;
    res_nxt.suppress   = (ch == CH_NONE) && (s1_code_r != SC_ESC);
    res_nxt.scan_echo  = s1_code_r;
    res_nxt.shift_held = shift_nxt;
    res_nxt.ctrl_held  = ctrl_nxt;
    res_nxt.alt_seen   = alt_nxt;
    res_nxt.caps_seen  = caps_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shift_r     <= 1'b0;
      ctrl_r      <= 1'b0;
      alt_r       <= 1'b0;
      caps_r      <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        shift_r <= shift_nxt;
        ctrl_r  <= ctrl_nxt;
        alt_r   <= alt_nxt;
        caps_r  <= caps_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_code_r <= in_ch.scan_code;
    end
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign in_ch.ready       = s1_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = res_r.ascii_char;
  assign out_ch.suppress   = res_r.suppress;
  assign out_ch.scan_echo  = res_r.scan_echo;
  assign out_ch.shift_held = res_r.shift_held;
  assign out_ch.ctrl_held  = res_r.ctrl_held;
  assign out_ch.alt_seen   = res_r.alt_seen;
  assign out_ch.caps_seen  = res_r.caps_seen;

`ifndef SYNTHESIS
  a_suppress_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.suppress ==
                     ((res_r.ascii_char == CH_NONE) && (res_r.scan_echo != SC_ESC))))
    else $error("suppress does not match character");

  a_alt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    alt_r |=> alt_r)
    else $error("alt flag cleared");

  a_caps_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    caps_r |=> caps_r)
    else $error("caps flag cleared");

  a_flags_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !s1_valid_r |-> (res_r.shift_held == shift_r) &&
                                   (res_r.ctrl_held == ctrl_r) &&
                                   (res_r.alt_seen == alt_r) &&
                                   (res_r.caps_seen == caps_r))
    else $error("reported flags differ from flag registers");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("beat stuck in input register");
`endif

endmodule
